[src/lpc_pkg.sv]
package lpc_pkg;

	// Longest frame that gets the keystream; later bytes pass through
	localparam int unsigned MaxFrameBytes = 255;
	localparam int unsigned QueueDepthDefault = 4;
	localparam int unsigned AesRounds = 10;

	localparam logic [7:0] BLOCK_A_TAG = 8'h01;
	localparam logic [7:0] RCON_FIRST = 8'h01;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_APP_KEY_HIGH = 3'd0,
		REG_APP_KEY_LOW = 3'd1,
		REG_NET_KEY_HIGH = 3'd2,
		REG_NET_KEY_LOW = 3'd3,
		REG_DEV_ADDR = 3'd4
	} reg_index_t;

	// One classified payload byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic pass;
		logic new_block;
		logic [3:0] idx;
		logic [15:0] counter;
		logic direction;
		logic use_app;
		logic [4:0] block_num;
	} desc_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX[x];
	endfunction

	// GF(2^8) doubling
	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[src/lpc_front.sv]
module lpc_front (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] payload_byte,
	input logic first_of_frame,
	input logic last_of_frame,
	input logic [15:0] frame_counter,
	input logic downlink,
	input logic [7:0] port,
	output lpc_pkg::desc_t desc
);

	logic [4:0] block_number_q;
	logic [3:0] byte_in_block_q;
	logic [15:0] held_counter_q;
	logic held_direction_q;
	logic use_app_key_q;

	logic new_frame;
	logic [4:0] eff_bn;
	logic [3:0] eff_bib;
	logic [8:0] pos;
	logic pass;
	logic [15:0] eff_ctr;
	logic eff_dir;
	logic eff_app;
	logic [3:0] next_bib;

	// Classify the byte against the running frame position
	always_comb begin
		new_frame = first_of_frame || (block_number_q == 5'd0);
		eff_bn = new_frame ? 5'd1 : block_number_q;
		eff_bib = new_frame ? 4'd0 : byte_in_block_q;
		eff_ctr = new_frame ? frame_counter : held_counter_q;
		eff_dir = new_frame ? downlink : held_direction_q;
		eff_app = new_frame ? (port != 8'd0) : use_app_key_q;
		pos = {eff_bn - 5'd1, eff_bib};
		pass = (pos >= 9'(lpc_pkg::MaxFrameBytes));
		next_bib = eff_bib + 4'd1;

		desc.data = payload_byte;
		desc.last = last_of_frame;
		desc.pass = pass;
		desc.new_block = !pass && (eff_bib == 4'd0);
		desc.idx = eff_bib;
		desc.counter = eff_ctr;
		desc.direction = eff_dir;
		desc.use_app = eff_app;
		desc.block_num = eff_bn;
	end

	// Frame position and latched frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_number_q <= '0;
			byte_in_block_q <= '0;
			held_counter_q <= '0;
			held_direction_q <= 1'b0;
			use_app_key_q <= 1'b0;
		end else if (accept) begin
			held_counter_q <= eff_ctr;
			held_direction_q <= eff_dir;
			use_app_key_q <= eff_app;
			if (last_of_frame) begin
				block_number_q <= '0;
				byte_in_block_q <= '0;
			end else if (pass) begin
				block_number_q <= eff_bn;
				byte_in_block_q <= eff_bib;
			end else begin
				byte_in_block_q <= next_bib;
				block_number_q <= (next_bib == 4'd0) ? eff_bn + 5'd1 : eff_bn;
			end
		end
	end

endmodule

[src/lpc_fifo.sv]
module lpc_fifo #(
	parameter int unsigned DEPTH = lpc_pkg::QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input lpc_pkg::desc_t wr_data,
	input logic rd_en,
	output lpc_pkg::desc_t rd_data,
	output logic full,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lpc_pkg::desc_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] count_q;

	assign full = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

endmodule

[src/lpc_aes.sv]
module lpc_aes (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [127:0] plain,
	input logic [127:0] key,
	output logic busy,
	output logic done,
	output logic [127:0] cipher
);

	logic [127:0] state_q;
	logic [127:0] rk_q;
	logic [7:0] rc_q;
	logic [3:0] round_q;
	logic busy_q;
	logic done_q;
	logic [127:0] next_rk;
	logic [127:0] next_state;

	// Next round key from the current one
	function automatic logic [127:0] expand(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t = {lpc_pkg::sbox(w3[23:16]) ^ rc, lpc_pkg::sbox(w3[15:8]),
			lpc_pkg::sbox(w3[7:0]), lpc_pkg::sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// SubBytes, ShiftRows, MixColumns (skipped in the final round), AddRoundKey
	function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
		input logic final_round);
		logic [7:0] sb [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				sb[4*c+i] = s[127 - 8*(4*((c+i) % 4) + i) -: 8];
				t[4*c+i] = lpc_pkg::sbox(sb[4*c+i]);
			end
		end
		if (!final_round) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c];
				a1 = t[4*c+1];
				a2 = t[4*c+2];
				a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c] = a0 ^ al ^ lpc_pkg::xt(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ lpc_pkg::xt(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ lpc_pkg::xt(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ lpc_pkg::xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8*i -: 8] = t[i] ^ rk[127 - 8*i -: 8];
		end
		return r;
	endfunction

	always_comb begin
		next_rk = expand(rk_q, rc_q);
		next_state = round_fn(state_q, next_rk, round_q == 4'(lpc_pkg::AesRounds));
	end

	assign busy = busy_q;
	assign done = done_q;
	assign cipher = state_q;

	// One round per cycle, key schedule on the fly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			round_q <= '0;
			rc_q <= lpc_pkg::RCON_FIRST;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				round_q <= 4'd1;
				rc_q <= lpc_pkg::RCON_FIRST;
			end else if (busy_q) begin
				rc_q <= lpc_pkg::xt(rc_q);
				round_q <= round_q + 4'd1;
				if (round_q == 4'(lpc_pkg::AesRounds)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			state_q <= plain ^ key;
			rk_q <= key;
		end else if (busy_q) begin
			state_q <= next_state;
			rk_q <= next_rk;
		end
	end

endmodule

[src/lpc_back.sv]
module lpc_back (
	input logic clk,
	input logic arst_n,
	input lpc_pkg::desc_t head,
	input logic head_valid,
	output logic head_pop,
	input logic [63:0] app_key_high,
	input logic [63:0] app_key_low,
	input logic [63:0] net_key_high,
	input logic [63:0] net_key_low,
	input logic [31:0] device_address,
	output logic aes_start,
	output logic aes_busy,
	input logic pop,
	output logic empty,
	output logic [7:0] out_byte,
	output logic last_out
);

	logic [127:0] ks_q;
	logic ks_done_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic last_out_q;

	logic [127:0] block_a;
	logic [127:0] key;
	logic aes_done;
	logic [127:0] aes_out;
	logic ready_to_go;
	logic slot_free;
	logic [7:0] ks_byte;

	// Block A and key for the head byte
	always_comb begin
		block_a = {lpc_pkg::BLOCK_A_TAG, 32'h0, 7'h0, head.direction,
			device_address[7:0], device_address[15:8],
			device_address[23:16], device_address[31:24],
			head.counter[7:0], head.counter[15:8], 24'h0, 3'h0, head.block_num};
		key = head.use_app ? {app_key_high, app_key_low} : {net_key_high, net_key_low};
	end

	lpc_aes u_aes (
		.clk(clk),
		.arst_n(arst_n),
		.start(aes_start),
		.plain(block_a),
		.key(key),
		.busy(aes_busy),
		.done(aes_done),
		.cipher(aes_out)
	);

	assign aes_start = head_valid && head.new_block && !ks_done_q && !aes_busy && !aes_done;
	assign slot_free = !out_valid_q || pop;
	assign ready_to_go = head.pass || !head.new_block || ks_done_q;
	assign head_pop = head_valid && ready_to_go && slot_free;
	assign ks_byte = ks_q[127 - 8*head.idx -: 8];

	assign empty = !out_valid_q;
	assign out_byte = out_byte_q;
	assign last_out = last_out_q;

	// Keystream holding and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (head_pop) begin
				ks_done_q <= 1'b0;
			end else if (aes_done) begin
				ks_done_q <= 1'b1;
			end
			if (head_pop) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (aes_done) begin
			ks_q <= aes_out;
		end
		if (head_pop) begin
			out_byte_q <= head.pass ? head.data : head.data ^ ks_byte;
			last_out_q <= head.last;
		end
	end

endmodule

[src/lorawan_payload_cipher.sv]
// LoRaWAN payload cipher: XORs payload bytes with an AES-128 keystream.
// Input channel: push/full. A byte is taken when push is high and full low;
// frame fields (counter, direction, port) are sampled on the first byte.
// Result channel: empty/pop. out_byte/last_out show the oldest result while
// empty is low; pop takes it. One result per input byte, in order.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects the
// key halves or the device address; other indexes are ignored. Write only
// while no bytes are in flight.
// A byte inside a block passes through the descriptor queue and the output
// register; the first byte of each 16-byte block also waits at the queue head
// for the iterative AES core, which runs 10 rounds of AES-128.
// A small descriptor queue lets the input side run ahead while the core works.
// Reset clears frame position, queue and output; keys reset to zero.
// When the receiver stalls the output register holds, the queue fills and
// full rises.
module lorawan_payload_cipher #(
	parameter int unsigned QUEUE_DEPTH = lpc_pkg::QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] payload_byte,
	input logic first_of_frame,
	input logic last_of_frame,
	input logic [15:0] frame_counter,
	input logic downlink,
	input logic [7:0] port,
	output logic empty,
	input logic pop,
	output logic [7:0] out_byte,
	output logic last_out,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);

	logic [63:0] app_key_high_q;
	logic [63:0] app_key_low_q;
	logic [63:0] net_key_high_q;
	logic [63:0] net_key_low_q;
	logic [31:0] device_address_q;

	logic accept;
	lpc_pkg::desc_t front_desc;
	lpc_pkg::desc_t head_desc;
	logic q_empty;
	logic head_pop;
	logic aes_start;
	logic aes_busy;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_key_high_q <= '0;
			app_key_low_q <= '0;
			net_key_high_q <= '0;
			net_key_low_q <= '0;
			device_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpc_pkg::REG_APP_KEY_HIGH: app_key_high_q <= cfg_data;
				lpc_pkg::REG_APP_KEY_LOW: app_key_low_q <= cfg_data;
				lpc_pkg::REG_NET_KEY_HIGH: net_key_high_q <= cfg_data;
				lpc_pkg::REG_NET_KEY_LOW: net_key_low_q <= cfg_data;
				lpc_pkg::REG_DEV_ADDR: device_address_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	lpc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.payload_byte(payload_byte),
		.first_of_frame(first_of_frame),
		.last_of_frame(last_of_frame),
		.frame_counter(frame_counter),
		.downlink(downlink),
		.port(port),
		.desc(front_desc)
	);

	lpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(accept),
		.wr_data(front_desc),
		.rd_en(head_pop),
		.rd_data(head_desc),
		.full(full),
		.empty(q_empty)
	);

	lpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head_desc),
		.head_valid(!q_empty),
		.head_pop(head_pop),
		.app_key_high(app_key_high_q),
		.app_key_low(app_key_low_q),
		.net_key_high(net_key_high_q),
		.net_key_low(net_key_low_q),
		.device_address(device_address_q),
		.aes_start(aes_start),
		.aes_busy(aes_busy),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.last_out(last_out)
	);

`ifndef SYNTH
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		aes_start |-> !aes_busy)
		else $error("keystream core restarted while busy");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> !q_empty)
		else $error("queue read while empty");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result dropped");
	a_passthru_no_aes: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && head_desc.pass) |-> !aes_start)
		else $error("keystream started for passthrough byte");
`endif

endmodule

[bench/tb_lorawan_payload_cipher.sv]
`timescale 1ns / 100ps

module tb_lorawan_payload_cipher;

	typedef struct {
		logic [7:0] data;
		logic first;
		logic last;
		logic [15:0] counter;
		logic dir;
		logic [7:0] port;
	} pbyte_t;

	typedef struct {
		logic [7:0] data;
		logic last;
	} cipher_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] payload_byte = '0;
	logic first_of_frame = 1'b0;
	logic last_of_frame = 1'b0;
	logic [15:0] frame_counter = '0;
	logic downlink = 1'b0;
	logic [7:0] port = '0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] out_byte;
	logic last_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	lorawan_payload_cipher dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: keys, address and frame position
	logic [63:0] app_hi, app_lo, net_hi, net_lo;
	logic [31:0] dev_addr;
	logic [7:0] ks [16];
	logic [4:0] blk_num;
	logic [3:0] blk_pos;
	logic [15:0] frm_cnt;
	logic frm_dir;
	logic frm_app;

	pbyte_t pending_bytes[$];
	cipher_out_t expected_bytes[$];
	int errors = 0;
	logic hold_req = 1'b0;
	logic rx_hold = 1'b0;

	function automatic logic [7:0] gf2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// AES-128 encryption of one block, byte 0 first
	function automatic void aes_encrypt(input logic [7:0] key [16], inout logic [7:0] s [16]);
		logic [7:0] rk [176];
		logic [7:0] t [16];
		logic [7:0] rc, w0, w1, w2, w3, tmp, a0, a1, a2, a3, al;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) rk[i] = key[i];
		for (int i = 16; i < 176; i += 4) begin
			w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
			if (i % 16 == 0) begin
				tmp = w0;
				w0 = lpc_pkg::SBOX[w1] ^ rc;
				w1 = lpc_pkg::SBOX[w2];
				w2 = lpc_pkg::SBOX[w3];
				w3 = lpc_pkg::SBOX[tmp];
				rc = gf2(rc);
			end
			rk[i] = rk[i-16] ^ w0;
			rk[i+1] = rk[i-15] ^ w1;
			rk[i+2] = rk[i-14] ^ w2;
			rk[i+3] = rk[i-13] ^ w3;
		end
		for (int i = 0; i < 16; i++) s[i] ^= rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[4*c+i] = lpc_pkg::SBOX[s[4*((c+i)%4)+i]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					t[4*c] = a0 ^ al ^ gf2(a0 ^ a1);
					t[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
					t[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
					t[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
		end
	endfunction

	function automatic void refresh_keystream();
		logic [7:0] key [16];
		logic [63:0] hi, lo;
		hi = frm_app ? app_hi : net_hi;
		lo = frm_app ? app_lo : net_lo;
		for (int i = 0; i < 8; i++) begin
			key[i] = hi[63-8*i -: 8];
			key[8+i] = lo[63-8*i -: 8];
		end
		for (int i = 0; i < 16; i++) ks[i] = 8'h00;
		ks[0] = 8'h01;
		ks[5] = {7'd0, frm_dir};
		for (int i = 0; i < 4; i++) ks[6+i] = dev_addr[8*i +: 8];
		ks[10] = frm_cnt[7:0];
		ks[11] = frm_cnt[15:8];
		ks[15] = {3'd0, blk_num};
		aes_encrypt(key, ks);
	endfunction

	function automatic cipher_out_t cipher_byte(input pbyte_t b);
		cipher_out_t r;
		int unsigned offs;
		r.data = b.data;
		r.last = b.last;
		if (b.first || blk_num == 0) begin
			frm_cnt = b.counter;
			frm_dir = b.dir;
			frm_app = (b.port != 0);
			blk_num = 5'd1;
			blk_pos = 4'd0;
		end
		offs = (blk_num - 1) * 16 + blk_pos;
		if (offs < lpc_pkg::MaxFrameBytes) begin
			if (blk_pos == 0) refresh_keystream();
			r.data = b.data ^ ks[blk_pos];
			blk_pos = blk_pos + 4'd1;
			if (blk_pos == 0) blk_num = blk_num + 5'd1;
		end
		if (b.last) begin
			blk_num = 5'd0;
			blk_pos = 4'd0;
		end
		return r;
	endfunction

	// Driver: offers queued bytes with random gaps
	int tx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_bytes.push_back(cipher_byte(pending_bytes.pop_front()));
				tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0;
			end
			if ((push && !full) || !push) begin
				if (tx_gap > 0) begin
					tx_gap--;
					push <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					push <= 1'b1;
					payload_byte <= pending_bytes[0].data;
					first_of_frame <= pending_bytes[0].first;
					last_of_frame <= pending_bytes[0].last;
					frame_counter <= pending_bytes[0].counter;
					downlink <= pending_bytes[0].dir;
					port <= pending_bytes[0].port;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here once requested
	initial begin
		wait (hold_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Monitor: random pop stalls, long hold-off on request
	int rx_gap = 0;
	always @(posedge clk) begin
		cipher_out_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected result byte %h last %b", $time, out_byte, last_out);
					errors++;
				end else begin
					e = expected_bytes.pop_front();
					if (out_byte !== e.data) begin
						$display("%0t: out_byte expected %h actual %h", $time, e.data, out_byte);
						errors++;
					end
					if (last_out !== e.last) begin
						$display("%0t: last_out expected %b actual %b", $time, e.last, last_out);
						errors++;
					end
				end
				rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0;
			end
			if (rx_hold) begin
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic write_reg(input lpc_pkg::reg_index_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lpc_pkg::REG_APP_KEY_HIGH: app_hi = val;
			lpc_pkg::REG_APP_KEY_LOW: app_lo = val;
			lpc_pkg::REG_NET_KEY_HIGH: net_hi = val;
			lpc_pkg::REG_NET_KEY_LOW: net_lo = val;
			lpc_pkg::REG_DEV_ADDR: dev_addr = val[31:0];
			default: ;
		endcase
	endtask

	task automatic write_unused_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_keys(input logic [63:0] ah, al, nh, nl, input logic [31:0] da);
		write_reg(lpc_pkg::REG_APP_KEY_HIGH, ah);
		write_reg(lpc_pkg::REG_APP_KEY_LOW, al);
		write_reg(lpc_pkg::REG_NET_KEY_HIGH, nh);
		write_reg(lpc_pkg::REG_NET_KEY_LOW, nl);
		write_reg(lpc_pkg::REG_DEV_ADDR, {32'd0, da});
	endtask

	task automatic add_byte(input logic [7:0] d, input logic f, l, input logic [15:0] c,
			input logic dr, input logic [7:0] p);
		pbyte_t b;
		b.data = d; b.first = f; b.last = l; b.counter = c; b.dir = dr; b.port = p;
		pending_bytes.push_back(b);
	endtask

	// Frame of n bytes with random content; fields random on non-first bytes
	task automatic add_frame(input int n, input logic [15:0] c, input logic dr,
			input logic [7:0] p);
		for (int i = 0; i < n; i++)
			add_byte(8'($urandom), i == 0, i == n - 1,
				i == 0 ? c : 16'($urandom), i == 0 ? dr : 1'($urandom),
				i == 0 ? p : 8'($urandom));
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || push || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int n;
		app_hi = '0; app_lo = '0; net_hi = '0; net_lo = '0; dev_addr = '0;
		blk_num = '0; blk_pos = '0; frm_cnt = '0; frm_dir = 1'b0; frm_app = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset keys, extremes of fields, both key selections
		add_byte(8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00);
		add_byte(8'hff, 1'b0, 1'b1, 16'hffff, 1'b1, 8'hff);
		add_byte(8'ha5, 1'b1, 1'b1, 16'hffff, 1'b1, 8'hff);
		drain();
		set_keys(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'hffffffffffffffff,
			64'hffffffffffffffff, 32'hffffffff);
		write_unused_reg(3'd5, '1);
		write_unused_reg(3'd7, '1);
		add_byte(8'h12, 1'b1, 1'b0, 16'h1234, 1'b1, 8'h01);
		// next byte closes the frame; the byte after it, with no open frame, is taken as a first byte
		add_byte(8'h34, 1'b0, 1'b1, 16'hbeef, 1'b0, 8'h00);
		add_byte(8'h56, 1'b0, 1'b0, 16'h0001, 1'b1, 8'h80);
		add_byte(8'h78, 1'b0, 1'b1, 16'h0002, 1'b0, 8'h00);
		// first_of_frame inside an open frame restarts it
		add_byte(8'h9a, 1'b1, 1'b0, 16'h00ff, 1'b0, 8'h00);
		add_byte(8'hbc, 1'b1, 1'b1, 16'hff00, 1'b1, 8'h7f);
		// over-long frame: bytes past the limit pass through
		add_frame(260, 16'hffff, 1'b1, 8'hff);
		drain();

		// Random phases with new keys (all zero in the last), long hold-off in the first
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 3) set_keys('0, '0, '0, '0, '0);
			else set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, $urandom);
			if (ph == 0) hold_req = 1'b1;
			n = 0;
			while (n < 200) begin
				if ($urandom_range(0, 9) == 0) begin
					add_byte(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
						1'($urandom), 8'($urandom));
					n++;
				end else begin
					int len;
					len = $urandom_range(0, 19) == 0 ? $urandom_range(200, 260)
						: $urandom_range(1, 40);
					add_frame(len, 16'($urandom), 1'($urandom),
						$urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom));
					n += len;
				end
			end
			drain();
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
